/* rtl/rbnp_pkg.sv */
// ----------------------------------------------------------------------------
// rbnp_pkg: shared constants for the ray/box nearest-pick block
// Field widths, word layout and reset values used by the slab-test datapath.
// ----------------------------------------------------------------------------
package rbnp_pkg;

    // Width of the node id kept by the nearest-hit tracker.
    localparam int NODE_BITS = 16;

    // Field widths of the stream words.
    localparam int COORD_W = 32;
    localparam int NODE_W  = 16;
    localparam int LIMIT_W = 16;
    localparam int S_DATA_W = NODE_W + 6 * COORD_W;
    localparam int M_DATA_W = 56;

    // Number of spatial axes walked by the sequencer.
    localparam int AXES = 3;

    // Reset value of the parallel limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;

    // Far sentinel: the initial exit distance and the saturated quotient.
    localparam logic [COORD_W-1:0] FAR_T = '1;

    // Item kinds carried on the input tuser bit.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W+1:0] dist_t;

endpackage

/* rtl/ray_box_nearest_pick.sv */
// ----------------------------------------------------------------------------
// ray_box_nearest_pick
// Ray picking against axis-aligned boxes by the slab test, with a tracker
// that keeps the nearest box hit over a run of boxes.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Words                        | Handshake
//  ---------+-----------+------------------------------+------------------------
//  s_*      | in        | ray load or box test         | s_tvalid / s_tready
//  m_*      | out       | one result per box test      | m_tvalid / m_tready
//  cfg_*    | in        | parallel limit register      | cfg_we, no back-pressure
//
// A load word produces no result and leaves s_tready high. A box test walks
// the three axes; an axis whose direction counts as parallel is settled in
// ST_AXIS, any other axis computes two quotients on the shared radix-4
// divider (ST_DSUB, ST_DPREP, ST_DIV, ST_DEND for each), then ST_ORDER,
// ST_NARROW and ST_CHECK update the interval; a quotient that saturates
// skips ST_DIV. s_tready stays low from a test until ST_FIN has loaded the
// result register. The result sits in an output register; a stalled m_tready
// holds the block in its final state until the register frees. Reset clears
// the ray and the tracker and sets the limit register to LIMIT_RESET; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module ray_box_nearest_pick
    import rbnp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration: parallel_limit.
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata fields from bit 0: node_id, first_x, first_y, first_z,
    // second_x, second_y, second_z.
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0: action.
    input  logic                s_tuser,
    // s_tlast: last_box.
    input  logic                s_tlast,
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata fields from bit 0: hit, entry_distance, pick_found,
    // picked_node, then six zero bits.
    output logic [M_DATA_W-1:0] m_tdata,
    // m_tlast: pick_done.
    output logic                m_tlast
);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_AXIS   = 4'd1;
    localparam logic [3:0] ST_DSUB   = 4'd2;
    localparam logic [3:0] ST_DPREP  = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_DEND   = 4'd5;
    localparam logic [3:0] ST_ORDER  = 4'd6;
    localparam logic [3:0] ST_NARROW = 4'd7;
    localparam logic [3:0] ST_CHECK  = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

    // Control registers.
    logic [3:0]          state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [1:0]          axis_reg, axis_next;
    logic                sel_reg, sel_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                hit_reg, hit_next;
    logic                m_valid_reg, m_valid_next;
    logic                best_valid_reg, best_valid_next;

    // Payload registers.
    coord_t              org_reg [AXES];
    coord_t              dir_reg [AXES];
    coord_t              lo_reg  [AXES];
    coord_t              hi_reg  [AXES];
    logic [NODE_W-1:0]   node_reg;
    logic                last_reg;
    logic signed [COORD_W:0] num_reg, num_next;
    logic [COORD_W-1:0]  dmag_reg, dmag_next;
    logic                dneg_reg, dneg_next;
    logic                qneg_reg, qneg_next;
    logic [COORD_W-1:0]  rem_reg, rem_next;
    logic [COORD_W-1:0]  shf_reg, shf_next;
    logic [COORD_W-1:0]  quo_reg, quo_next;
    dist_t               t1_reg, t1_next;
    dist_t               t2_reg, t2_next;
    dist_t               enter_reg, enter_next;
    dist_t               exit_reg, exit_next;
    logic [COORD_W-1:0]  best_dist_reg, best_dist_next;
    logic [NODE_BITS-1:0] best_node_reg, best_node_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    // Handshakes.
    logic s_fire;
    logic load_fire;
    logic test_fire;
    logic out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign load_fire = s_fire && (s_tuser == ACT_LOAD);
    assign test_fire = s_fire && (s_tuser == ACT_TEST);
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Operands of the current axis.
    coord_t o_cur, d_cur, lo_cur, hi_cur, bound_cur;
    logic [COORD_W-1:0] dmag_cur;
    logic               parallel_cur;
    logic               outside_cur;

    always_comb begin
        o_cur        = org_reg[axis_reg];
        d_cur        = dir_reg[axis_reg];
        lo_cur       = lo_reg[axis_reg];
        hi_cur       = hi_reg[axis_reg];
        bound_cur    = sel_reg ? hi_cur : lo_cur;
        dmag_cur     = d_cur[COORD_W-1] ? (~d_cur + 1'b1) : d_cur;
        parallel_cur = (dmag_cur == '0) ||
                       (dmag_cur < {{(COORD_W-LIMIT_W){1'b0}}, limit_reg});
        outside_cur  = (o_cur < lo_cur) || (o_cur > hi_cur);
    end

    // Numerator magnitude and saturation test.
    logic [COORD_W:0]     nmag;
    logic                 sat;

    always_comb begin
        nmag = num_reg[COORD_W] ? 33'(-num_reg) : 33'(num_reg);
        sat  = {15'd0, nmag} >= {dmag_reg, 16'd0};
    end

    // Two restoring division steps per cycle.
    logic [COORD_W-1:0] div_rem;
    logic [COORD_W-1:0] div_shf;
    logic [COORD_W-1:0] div_quo;
    logic [COORD_W:0]   div_trial;

    always_comb begin
        div_rem = rem_reg;
        div_shf = shf_reg;
        div_quo = quo_reg;
        div_trial = '0;
        for (int k = 0; k < 2; k++) begin
            div_trial = {div_rem, div_shf[COORD_W-1]};
            if (div_trial >= {1'b0, dmag_reg}) begin
                div_rem = 32'(div_trial - {1'b0, dmag_reg});
                div_quo = {div_quo[COORD_W-2:0], 1'b1};
            end else begin
                div_rem = div_trial[COORD_W-1:0];
                div_quo = {div_quo[COORD_W-2:0], 1'b0};
            end
            div_shf = {div_shf[COORD_W-2:0], 1'b0};
        end
    end

    // Signed quotient from the magnitude.
    dist_t t_signed;

    always_comb begin
        t_signed = qneg_reg ? -dist_t'({2'b00, quo_reg}) : dist_t'({2'b00, quo_reg});
    end

    // Tracker update on the final cycle of a test.
    logic                 take;
    logic                 found;
    logic [NODE_BITS-1:0] win_node;
    logic [NODE_BITS-1:0] node_kept;

    always_comb begin
        node_kept = NODE_BITS'(node_reg);
        take      = hit_reg &&
                    (!best_valid_reg || (enter_reg[COORD_W-1:0] < best_dist_reg));
        found     = best_valid_reg || take;
        win_node  = take ? node_kept : best_node_reg;
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        sel_next        = sel_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        num_next        = num_reg;
        dmag_next       = dmag_reg;
        dneg_next       = dneg_reg;
        qneg_next       = qneg_reg;
        rem_next        = rem_reg;
        shf_next        = shf_reg;
        quo_next        = quo_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        enter_next      = enter_reg;
        exit_next       = exit_reg;
        best_dist_next  = best_dist_reg;
        best_node_next  = best_node_reg;
        best_valid_next = best_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (test_fire) begin
                    axis_next  = '0;
                    hit_next   = 1'b1;
                    enter_next = '0;
                    exit_next  = dist_t'({2'b00, FAR_T});
                    state_next = ST_AXIS;
                end
            end
            // Parallel axes are settled here; others start two quotients.
            ST_AXIS: begin
                dmag_next = dmag_cur;
                dneg_next = d_cur[COORD_W-1];
                sel_next  = 1'b0;
                if (parallel_cur) begin
                    if (outside_cur) begin
                        hit_next   = 1'b0;
                        state_next = ST_FIN;
                    end else if (axis_reg == LAST_AXIS) begin
                        state_next = ST_FIN;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                    end
                end else begin
                    state_next = ST_DSUB;
                end
            end
            ST_DSUB: begin
                num_next   = {bound_cur[COORD_W-1], bound_cur} -
                             {o_cur[COORD_W-1], o_cur};
                state_next = ST_DPREP;
            end
            // Quotients of 2^32 or more saturate without iterating.
            ST_DPREP: begin
                qneg_next = num_reg[COORD_W] ^ dneg_reg;
                rem_next  = {15'd0, nmag[COORD_W:16]};
                shf_next  = {nmag[15:0], 16'd0};
                quo_next  = '0;
                cnt_next  = '0;
                if (sat) begin
                    quo_next   = FAR_T;
                    state_next = ST_DEND;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = div_rem;
                shf_next = div_shf;
                quo_next = div_quo;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_DEND;
                end
            end
            ST_DEND: begin
                if (!sel_reg) begin
                    t1_next    = t_signed;
                    sel_next   = 1'b1;
                    state_next = ST_DSUB;
                end else begin
                    t2_next    = t_signed;
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER: begin
                if (t1_reg > t2_reg) begin
                    t1_next = t2_reg;
                    t2_next = t1_reg;
                end
                state_next = ST_NARROW;
            end
            ST_NARROW: begin
                if (t1_reg > enter_reg) begin
                    enter_next = t1_reg;
                end
                if (t2_reg < exit_reg) begin
                    exit_next = t2_reg;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (enter_reg > exit_reg) begin
                    hit_next   = 1'b0;
                    state_next = ST_FIN;
                end else if (axis_reg == LAST_AXIS) begin
                    state_next = ST_FIN;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_AXIS;
                end
            end
            // Deliver the result word and update or clear the tracker.
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = last_reg;
                    m_data_next  = '0;
                    m_data_next[0]    = hit_reg;
                    m_data_next[32:1] = hit_reg ? enter_reg[COORD_W-1:0] : '0;
                    m_data_next[33]   = last_reg && found;
                    m_data_next[49:34] = (last_reg && found) ? NODE_W'(win_node) : '0;
                    if (last_reg) begin
                        best_dist_next  = FAR_T;
                        best_node_next  = '0;
                        best_valid_next = 1'b0;
                    end else if (take) begin
                        best_dist_next  = enter_reg[COORD_W-1:0];
                        best_node_next  = node_kept;
                        best_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            axis_reg       <= '0;
            sel_reg        <= 1'b0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            best_dist_reg  <= FAR_T;
            best_node_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            sel_reg        <= sel_next;
            cnt_reg        <= cnt_next;
            hit_reg        <= hit_next;
            m_valid_reg    <= m_valid_next;
            best_valid_reg <= best_valid_next;
            best_dist_reg  <= best_dist_next;
            best_node_reg  <= best_node_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Ray registers: cleared by reset, written by a load word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                org_reg[a] <= '0;
                dir_reg[a] <= '0;
            end
        end else if (load_fire) begin
            for (int a = 0; a < AXES; a++) begin
                org_reg[a] <= s_tdata[NODE_W + a*COORD_W +: COORD_W];
                dir_reg[a] <= s_tdata[NODE_W + (a+AXES)*COORD_W +: COORD_W];
            end
        end
    end

    // Box and datapath payload registers.
    always_ff @(posedge aclk) begin
        if (test_fire) begin
            for (int a = 0; a < AXES; a++) begin
                lo_reg[a] <= s_tdata[NODE_W + a*COORD_W +: COORD_W];
                hi_reg[a] <= s_tdata[NODE_W + (a+AXES)*COORD_W +: COORD_W];
            end
            node_reg <= s_tdata[NODE_W-1:0];
            last_reg <= s_tlast;
        end
        num_reg    <= num_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        qneg_reg   <= qneg_next;
        rem_reg    <= rem_next;
        shf_reg    <= shf_next;
        quo_reg    <= quo_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        enter_reg  <= enter_next;
        exit_reg   <= exit_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // The partial remainder always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < dmag_reg))
        else $error("divider remainder not below divisor");

    // A missed box reports a zero entry distance.
    a_miss_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[32:1] == '0))
        else $error("entry distance set on a miss");

    // Winner fields appear only on the last box of a pick.
    a_winner_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_data_reg[49:33] == '0))
        else $error("winner reported before the last box");

    // A box test makes the block busy on the next cycle.
    a_test_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        test_fire |=> !s_tready)
        else $error("input ready right after a box test");

    // The tracker is empty after the last box of a pick.
    a_tracker_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free && last_reg) |=> !best_valid_reg)
        else $error("tracker not cleared after last box");

endmodule

/* tb/ray_box_nearest_pick_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_nearest_pick_tb: self-checking bench for the slab-test picker
// Streams ray loads and box tests into the block, works out each hit, entry
// distance and nearest-node winner alongside, and compares every result word
// as it leaves. Covers directed corner cases, several parallel limits,
// random picks under random idling, and a long output stall.
// ----------------------------------------------------------------------------
module ray_box_nearest_pick_tb;
    import rbnp_pkg::*;

    localparam int          STALL_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          RX_HOLD       = 400;
    localparam int          MAX_REPORTS   = 10;
    localparam longint      FAR_DIST      = 64'h0000_0000_FFFF_FFFF;

    // One input word as fields.
    typedef struct packed {
        logic                      action;
        logic [NODE_W-1:0]         node;
        logic [2:0][COORD_W-1:0]   first;
        logic [2:0][COORD_W-1:0]   second;
        logic                      last;
    } stim_item_t;

    // One result word as fields.
    typedef struct packed {
        logic                hit;
        logic [COORD_W-1:0]  entry;
        logic                done;
        logic                found;
        logic [NODE_W-1:0]   node;
    } box_result_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // node_id, first_x/y/z, second_x/y/z from bit 0
    logic                s_tuser;   // action
    logic                s_tlast;   // last_box
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // hit, entry_distance, pick_found, picked_node
    logic                m_tlast;   // pick_done

    // Predictor state.
    logic [LIMIT_W-1:0]        par_limit   = LIMIT_RESET;
    logic [2:0][COORD_W-1:0]   ray_org     = '0;
    logic [2:0][COORD_W-1:0]   ray_dir     = '0;
    logic [COORD_W-1:0]        best_dist   = FAR_T;
    logic [NODE_W-1:0]         best_node   = '0;
    logic                      best_valid  = 1'b0;

    box_result_t box_results_q[$];
    int          fail_count    = 0;
    int          idle_cycles   = 0;
    int          tx_burst_left = 0;
    logic        tx_steady     = 1'b0;
    logic        rx_hold_req   = 1'b0;

    ray_box_nearest_pick u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Slab-test predictor
    // ------------------------------------------------------------------------
    function automatic longint widen(input logic [COORD_W-1:0] v);
        return $signed(v);
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Signed Q16.16 quotient with the magnitude saturated at the far sentinel.
    function automatic longint slab_quotient(input longint num, input longint den);
        longint unsigned q;
        q = (magnitude(num) << 16) / magnitude(den);
        if (q > FAR_DIST) begin
            q = FAR_DIST;
        end
        if ((num < 0) != (den < 0)) begin
            return -$signed(q);
        end
        return $signed(q);
    endfunction

    // Applies one accepted word to the predictor and queues its result, if any.
    function automatic void slab_pick_predict(input stim_item_t it);
        box_result_t r;
        logic        hit;
        longint      t_in, t_out, o, d, lo, hi, t1, t2, tmp;
        if (it.action == ACT_LOAD) begin
            ray_org = it.first;
            ray_dir = it.second;
            return;
        end
        hit   = 1'b1;
        t_in  = 0;
        t_out = FAR_DIST;
        for (int a = 0; a < AXES; a++) begin
            if (hit) begin
                o  = widen(ray_org[a]);
                d  = widen(ray_dir[a]);
                lo = widen(it.first[a]);
                hi = widen(it.second[a]);
                // A zero direction is parallel whatever the limit says.
                if (d == 0 || magnitude(d) < par_limit) begin
                    if (o < lo || o > hi) begin
                        hit = 1'b0;
                    end
                end else begin
                    t1 = slab_quotient(lo - o, d);
                    t2 = slab_quotient(hi - o, d);
                    if (t1 > t2) begin
                        tmp = t1;
                        t1  = t2;
                        t2  = tmp;
                    end
                    if (t1 > t_in) begin
                        t_in = t1;
                    end
                    if (t2 < t_out) begin
                        t_out = t2;
                    end
                    if (t_in > t_out) begin
                        hit = 1'b0;
                    end
                end
            end
        end
        // Ties keep the earlier node.
        if (hit && (!best_valid || t_in[COORD_W-1:0] < best_dist)) begin
            best_dist  = t_in[COORD_W-1:0];
            best_node  = it.node;
            best_valid = 1'b1;
        end
        r.hit   = hit;
        r.entry = hit ? t_in[COORD_W-1:0] : '0;
        r.done  = it.last;
        r.found = it.last && best_valid;
        r.node  = (it.last && best_valid) ? best_node : '0;
        box_results_q.push_back(r);
        if (it.last) begin
            best_dist  = FAR_T;
            best_node  = '0;
            best_valid = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] fix(input int units);
        return 32'(units <<< 16);
    endfunction

    function automatic logic [COORD_W-1:0] spread(input int bits);
        int span;
        span = 1 << bits;
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic stim_item_t make_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                            input logic last);
        stim_item_t it;
        it.action = ACT_LOAD;
        it.node   = '0;
        it.first  = {oz, oy, ox};
        it.second = {dz, dy, dx};
        it.last   = last;
        return it;
    endfunction

    function automatic stim_item_t make_box(input logic [NODE_W-1:0] node,
                                            input logic [31:0] lx, ly, lz, hx, hy, hz,
                                            input logic last);
        stim_item_t it;
        it.action = ACT_TEST;
        it.node   = node;
        it.first  = {lz, ly, lx};
        it.second = {hz, hy, hx};
        it.last   = last;
        return it;
    endfunction

    function automatic stim_item_t random_word();
        stim_item_t it;
        it.action = 1'($urandom_range(0, 1));
        it.node   = 16'($urandom);
        it.last   = 1'($urandom_range(0, 1));
        for (int a = 0; a < AXES; a++) begin
            it.first[a]  = $urandom;
            it.second[a] = $urandom;
        end
        return it;
    endfunction

    // Ray with moderate origin and a mix of zero, tiny, near-limit and full directions.
    function automatic stim_item_t random_ray();
        stim_item_t it;
        it = make_ray('0, '0, '0, '0, '0, '0, 1'($urandom_range(0, 1)));
        it.node = 16'($urandom);
        for (int a = 0; a < AXES; a++) begin
            it.first[a] = spread(24);
            case ($urandom_range(0, 7))
                0:       it.second[a] = '0;
                1:       it.second[a] = spread(2);
                2:       it.second[a] = spread(16);
                3:       it.second[a] = $urandom;
                default: it.second[a] = spread(18);
            endcase
        end
        return it;
    endfunction

    // Box around a point of the ray, sometimes behind the origin.
    function automatic stim_item_t aimed_box(input stim_item_t ray);
        stim_item_t it;
        longint     t, p;
        it = make_box(16'($urandom), '0, '0, '0, '0, '0, '0, 1'b0);
        t  = longint'($urandom_range(0, 1 << 21)) - (1 << 18);
        for (int a = 0; a < AXES; a++) begin
            p = widen(ray.first[a]) + ((widen(ray.second[a]) * t) >>> 16);
            it.first[a]  = 32'(p - longint'($urandom_range(0, 1 << 18)));
            it.second[a] = 32'(p + longint'($urandom_range(0, 1 << 18)));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one word per call, in bursts with random gaps
    // ------------------------------------------------------------------------
    task automatic send_word(input stim_item_t it);
        int gap;
        gap = 0;
        if (!tx_steady) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 24);
                case ($urandom_range(0, 7))
                    0:       gap = $urandom_range(12, 40);
                    1, 2:    gap = 0;
                    default: gap = $urandom_range(1, 6);
                endcase
            end
            tx_burst_left--;
        end
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tlast  <= it.last;
        s_tdata  <= {it.second, it.first, it.node};
        do @(posedge aclk); while (!s_tready);
        slab_pick_predict(it);
    endtask

    // Lets every expected word arrive and any trailing load finish.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (box_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        tx_burst_left = 0;
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        par_limit = value;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-built picks: reset ray, ignored last on loads, ties, extremes, saturation.
    task automatic test_directed_picks();
        // The reset ray has zero direction, so every axis is an inside check.
        send_word(make_box(16'h0000, fix(-1), fix(-1), fix(-1), fix(1), fix(1), fix(1), 1'b0));
        send_word(make_box(16'hFFFF, fix(1), fix(1), fix(1), fix(2), fix(2), fix(2), 1'b1));
        // Load words carrying last must leave the tracker alone.
        send_word(make_ray('0, '0, '0, fix(1), '0, '0, 1'b1));
        send_word(make_box(16'd1, fix(2), fix(-1), fix(-1), fix(3), fix(1), fix(1), 1'b0));
        send_word(make_ray('0, '0, '0, fix(1), '0, '0, 1'b1));
        send_word(make_box(16'd2, fix(-3), fix(-1), fix(-1), fix(-2), fix(1), fix(1), 1'b0));
        send_word(make_box(16'd3, fix(1), fix(2), fix(-1), fix(4), fix(3), fix(1), 1'b0));
        // Inverted on a dividing axis: entry equals the earlier hit, so it loses the tie.
        send_word(make_box(16'd4, fix(3), fix(-1), fix(-1), fix(2), fix(1), fix(1), 1'b0));
        send_word(make_box(16'd5, 32'h0001_8000, fix(-1), fix(-1), fix(2), fix(1), fix(1),
                           1'b1));
        // One-LSB directions from the most negative corner: quotients saturate.
        send_word(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h1, 32'h1, 32'h1, 1'b0));
        send_word(make_box(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_word(make_box(16'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        send_word(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_word(make_box(16'd7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        // Negative, fractional and tiny directions together.
        send_word(make_ray('0, '0, '0, fix(-1), 32'h8000, 32'd3, 1'b0));
        send_word(make_box(16'd8, fix(-4), fix(0), fix(0), fix(-1), fix(4), fix(1), 1'b1));
    endtask

    // Parallel limit at its extremes: zero still treats a zero direction as parallel.
    task automatic test_parallel_limit();
        set_limit(16'h0000);
        send_word(make_ray('0, '0, '0, '0, fix(1), '0, 1'b0));
        send_word(make_box(16'd10, fix(-1), fix(1), fix(-1), fix(1), fix(2), fix(1), 1'b0));
        send_word(make_box(16'd11, fix(1), fix(1), fix(-1), fix(2), fix(2), fix(1), 1'b1));
        set_limit(16'hFFFF);
        send_word(make_ray('0, '0, '0, 32'h8000, fix(1), 32'hFFFF_0001, 1'b0));
        send_word(make_box(16'd12, fix(-1), fix(2), fix(-4), fix(1), fix(3), fix(4), 1'b0));
        send_word(make_box(16'd13, fix(1), fix(2), fix(-4), fix(2), fix(3), fix(4), 1'b1));
    endtask

    // Mostly well-formed picks (load then a run of boxes ending in last) plus noise.
    task automatic test_random_picks(input logic [LIMIT_W-1:0] limit, input int n_items);
        stim_item_t ray, box, prev, extra;
        int         sent, boxes, pick;
        set_limit(limit);
        sent = 0;
        prev = '0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(random_word());
                sent++;
            end else begin
                ray = random_ray();
                send_word(ray);
                sent++;
                boxes = $urandom_range(1, 8);
                for (int b = 0; b < boxes; b++) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) begin
                        box = random_word();
                        box.action = ACT_TEST;
                    end else if (pick == 1 && b > 0) begin
                        // Same box again under another id: a tie.
                        box = prev;
                        box.node = 16'($urandom);
                    end else begin
                        box = aimed_box(ray);
                        if (pick == 2) begin
                            extra      = aimed_box(ray);
                            box.first  = extra.second;
                        end
                    end
                    box.last = (b == boxes - 1);
                    send_word(box);
                    sent++;
                    prev = box;
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while boxes keep coming back to back.
    task automatic test_output_backpressure();
        stim_item_t ray, box;
        settle();
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        ray = make_ray('0, '0, '0, '0, '0, fix(1), 1'b0);
        send_word(ray);
        for (int i = 0; i < 16; i++) begin
            box = aimed_box(ray);
            box.last = (i == 15);
            send_word(box);
        end
        tx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: m_tready on a changing pattern, with an optional long hold-off
    // ------------------------------------------------------------------------
    initial begin
        rx_mode_t mode;
        int       left;
        int       phase;
        m_tready = 1'b0;
        mode     = RX_FREE;
        left     = 0;
        phase    = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            left--;
            phase++;
            case (mode)
                RX_FREE:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_tready <= (phase % 4 != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        box_result_t got, want;
        logic [M_DATA_W-51:0] pad;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit   = m_tdata[0];
            got.entry = m_tdata[32:1];
            got.found = m_tdata[33];
            got.node  = m_tdata[49:34];
            got.done  = m_tlast;
            pad       = m_tdata[M_DATA_W-1:50];
            if (box_results_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result word %h, tlast %b", m_tdata, m_tlast);
                end
            end else begin
                want = box_results_q.pop_front();
                if (got.hit !== want.hit || got.entry !== want.entry ||
                    got.done !== want.done || got.found !== want.found ||
                    got.node !== want.node || pad !== '0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: expected hit %b entry %h done %b found %b node %h",
                                 want.hit, want.entry, want.done, want.found, want.node);
                        $display("          got      hit %b entry %h done %b found %b node %h pad %h",
                                 got.hit, got.entry, got.done, got.found, got.node, pad);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_LOAD;
        s_tlast   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_picks();
        test_parallel_limit();
        test_random_picks(LIMIT_RESET, 200);
        test_random_picks(16'h0000, 200);
        test_output_backpressure();
        test_random_picks(16'hFFFF, 200);
        test_random_picks(16'($urandom_range(2, 16'hFFFE)), 200);
        test_random_picks(16'($urandom_range(0, 8)), 200);
        settle();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
